// ===== hdl/cdda_pkg.sv =====
// ----------------------------------------------------------------------------
// cdda_pkg
// Shared types, constants and calendar helper functions for the date
// day-arithmetic block.
// ----------------------------------------------------------------------------
`default_nettype none

package cdda_pkg;

	// first year of the supported range, day 0 is its first of January
	localparam logic [11:0] FIRST_YEAR = 12'd1970;
	// residue of (day 0 + 4) mod 7, 1970-01-01 was a Thursday
	localparam logic [2:0]  EPOCH_WD   = 3'd4;
	localparam logic [3:0]  LAST_MONTH = 4'd12;
	localparam logic [8:0]  YEAR_DAYS  = 9'd365;
	localparam logic [8:0]  LEAP_DAYS  = 9'd366;
	localparam int          ACC_W      = 18;

	typedef logic [ACC_W-1:0] acc_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_YEAR_FWD,
		ST_MONTH_FWD,
		ST_DAY,
		ST_OFFSET,
		ST_RANGE,
		ST_YEAR_BACK,
		ST_MONTH_BACK,
		ST_DONE
	} state_t;

	// operation request to the shared adder
	typedef struct packed {
		logic sub;
		acc_t operand;
	} alu_req_t;

	// result of the shared adder
	typedef struct packed {
		logic neg;
		acc_t sum;
	} alu_rsp_t;

	// within 1970..2099 divisibility by 4 alone decides a leap year
	function automatic logic is_leap(input logic [11:0] year);
		return (year[1:0] == 2'b00);
	endfunction

	// length of a month, months outside 1..12 read as 31
	function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		len = 5'd31;
		if (month == 4'd2) begin
			len = leap ? 5'd29 : 5'd28;
		end else if (month inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
			len = 5'd30;
		end
		return len;
	endfunction

	// 5-bit value modulo 7 by compare-and-subtract
	function automatic logic [2:0] mod7(input logic [4:0] v);
		logic [4:0] r;
		r = v;
		if (r >= 5'd28) begin
			r = r - 5'd28;
		end else if (r >= 5'd21) begin
			r = r - 5'd21;
		end else if (r >= 5'd14) begin
			r = r - 5'd14;
		end else if (r >= 5'd7) begin
			r = r - 5'd7;
		end
		return r[2:0];
	endfunction

	// add two weekday residues modulo 7
	function automatic logic [2:0] wd_add(input logic [2:0] a, input logic [2:0] b);
		logic [3:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= 4'd7) begin
			s = s - 4'd7;
		end
		return s[2:0];
	endfunction

	// day count from the first year to the first of January of a year,
	// evaluated at elaboration only
	function automatic int unsigned days_before_year(input int unsigned year);
		int unsigned total;
		int unsigned i;
		total = 0;
		for (i = 32'(FIRST_YEAR); i < year; i++) begin
			total += is_leap(12'(i)) ? 32'(LEAP_DAYS) : 32'(YEAR_DAYS);
		end
		return total;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/cdda_if.sv =====
// ----------------------------------------------------------------------------
// cdda_if
// Valid/ready channel interfaces for the date request and its result.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdda_req_if;
	logic        valid;
	logic        ready;
	logic [5:0]  in_day;
	logic [3:0]  in_month;
	logic [11:0] in_year;
	logic signed [15:0] day_offset;

	modport source (output valid, in_day, in_month, in_year, day_offset, input ready);
	modport sink   (input valid, in_day, in_month, in_year, day_offset, output ready);
endinterface

interface cdda_rsp_if;
	logic        valid;
	logic        ready;
	logic        date_valid;
	logic [14:0] days_since_epoch;
	logic [2:0]  weekday;
	logic        shift_in_range;
	logic [4:0]  out_day;
	logic [3:0]  out_month;
	logic [11:0] out_year;

	modport source (output valid, date_valid, days_since_epoch, weekday, shift_in_range,
		out_day, out_month, out_year, input ready);
	modport sink   (input valid, date_valid, days_since_epoch, weekday, shift_in_range,
		out_day, out_month, out_year, output ready);
endinterface

`default_nettype wire

// ===== hdl/cdda_alu.sv =====
// ----------------------------------------------------------------------------
// cdda_alu
// Shared add/subtract unit for the day count accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module cdda_alu (
	input  wire cdda_pkg::acc_t     acc,
	input  wire cdda_pkg::alu_req_t req,
	output cdda_pkg::alu_rsp_t      rsp
);

	cdda_pkg::acc_t sum;

	// two's complement add, subtract by inverted operand and carry in
	assign sum     = acc + (req.sub ? ~req.operand : req.operand)
		+ cdda_pkg::acc_t'(req.sub);
	assign rsp.sum = sum;
	assign rsp.neg = sum[cdda_pkg::ACC_W-1];

endmodule

`default_nettype wire

// ===== hdl/calendar_date_day_arithmetic.sv =====
// ----------------------------------------------------------------------------
// calendar_date_day_arithmetic
// Gregorian date check, day count since 1970-01-01, weekday and date shift.
// ----------------------------------------------------------------------------
// One request is processed at a time by a small sequencer around a single
// add/subtract unit. A valid date walks forward year by year and month by
// month, adds the day and the offset and checks the shifted count. If the
// shifted date is in range, a year walk and a month walk convert it back.
// The done state hands over the result and the idle state takes the next
// request. The year walks move one year per cycle on the shared adder. An
// invalid date goes straight to the done state, a shift out of range right
// after the forward walk. A finished result waits in the output register
// while the next request is already taken. No memories.
`default_nettype none

module calendar_date_day_arithmetic #(
	parameter int unsigned LAST_YEAR = 2050
) (
	input  wire  clk,
	input  wire  arst_n,
	cdda_req_if.sink   req,
	cdda_rsp_if.source rsp
);

	localparam int unsigned  LIMIT_INT = cdda_pkg::days_before_year(LAST_YEAR + 1);
	localparam cdda_pkg::acc_t LIMIT   = cdda_pkg::acc_t'(LIMIT_INT);
	localparam logic [11:0]  YEAR_MAX  = 12'(LAST_YEAR);

	cdda_pkg::state_t state_q, state_d;

	// request capture
	logic [5:0]  d_q;
	logic [3:0]  m_q;
	logic [11:0] y_q;
	logic [15:0] off_q;
	logic        valid_q;
	logic        in_range_q;

	// walk registers
	cdda_pkg::acc_t acc_q;
	logic [15:0] days_q;
	logic [2:0]  wd_q;
	logic [11:0] yi_q;
	logic [3:0]  mi_q;

	// output register
	logic        out_valid_q;
	logic        o_date_valid_q;
	logic [14:0] o_days_q;
	logic [2:0]  o_weekday_q;
	logic        o_shift_q;
	logic [4:0]  o_day_q;
	logic [3:0]  o_month_q;
	logic [11:0] o_year_q;

	logic req_fire;
	logic out_free;
	logic in_valid;
	logic leap_i;
	logic [8:0] ylen_i;
	logic [4:0] mlen_i;
	logic [4:0] dm1;
	logic       acc_in_range;
	cdda_pkg::alu_req_t alu_req;
	cdda_pkg::alu_rsp_t alu_rsp;

	assign req_fire = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == cdda_pkg::ST_IDLE);

	// input date check
	assign in_valid = (req.in_year >= cdda_pkg::FIRST_YEAR) && (req.in_year <= YEAR_MAX)
		&& (req.in_month >= 4'd1) && (req.in_month <= cdda_pkg::LAST_MONTH)
		&& (req.in_day >= 6'd1)
		&& (req.in_day <= {1'b0, cdda_pkg::month_len(req.in_month,
			cdda_pkg::is_leap(req.in_year))});

	// lengths of the year and month under the walk pointers
	assign leap_i = cdda_pkg::is_leap(yi_q);
	assign ylen_i = leap_i ? cdda_pkg::LEAP_DAYS : cdda_pkg::YEAR_DAYS;
	assign mlen_i = cdda_pkg::month_len(mi_q, leap_i);
	assign dm1    = d_q[4:0] - 5'd1;
	assign acc_in_range = !acc_q[cdda_pkg::ACC_W-1] && (acc_q < LIMIT);

	cdda_alu u_alu (
		.acc (acc_q),
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			cdda_pkg::ST_IDLE: begin
				if (req_fire) begin
					state_d = in_valid ? cdda_pkg::ST_YEAR_FWD : cdda_pkg::ST_DONE;
				end
			end
			cdda_pkg::ST_YEAR_FWD: begin
				if (yi_q == y_q) begin
					state_d = cdda_pkg::ST_MONTH_FWD;
				end
			end
			cdda_pkg::ST_MONTH_FWD: begin
				if (mi_q == m_q) begin
					state_d = cdda_pkg::ST_DAY;
				end
			end
			cdda_pkg::ST_DAY:    state_d = cdda_pkg::ST_OFFSET;
			cdda_pkg::ST_OFFSET: state_d = cdda_pkg::ST_RANGE;
			cdda_pkg::ST_RANGE: begin
				state_d = acc_in_range ? cdda_pkg::ST_YEAR_BACK : cdda_pkg::ST_DONE;
			end
			cdda_pkg::ST_YEAR_BACK: begin
				if (alu_rsp.neg) begin
					state_d = cdda_pkg::ST_MONTH_BACK;
				end
			end
			cdda_pkg::ST_MONTH_BACK: begin
				if (mi_q == cdda_pkg::LAST_MONTH || alu_rsp.neg) begin
					state_d = cdda_pkg::ST_DONE;
				end
			end
			cdda_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = cdda_pkg::ST_IDLE;
				end
			end
			default: state_d = cdda_pkg::ST_IDLE;
		endcase
	end

	// shared adder operand select
	always_comb begin
		alu_req.sub     = 1'b0;
		alu_req.operand = '0;
		case (state_q)
			cdda_pkg::ST_YEAR_FWD:   alu_req.operand = cdda_pkg::acc_t'(ylen_i);
			cdda_pkg::ST_MONTH_FWD:  alu_req.operand = cdda_pkg::acc_t'(mlen_i);
			cdda_pkg::ST_DAY:        alu_req.operand = cdda_pkg::acc_t'(dm1);
			cdda_pkg::ST_OFFSET: begin
				alu_req.operand = {{(cdda_pkg::ACC_W-16){off_q[15]}}, off_q};
			end
			cdda_pkg::ST_YEAR_BACK: begin
				alu_req.sub     = 1'b1;
				alu_req.operand = cdda_pkg::acc_t'(ylen_i);
			end
			cdda_pkg::ST_MONTH_BACK: begin
				alu_req.sub     = 1'b1;
				alu_req.operand = cdda_pkg::acc_t'(mlen_i);
			end
			default: begin
				alu_req.sub     = 1'b0;
				alu_req.operand = '0;
			end
		endcase
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cdda_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// request capture and walk datapath
	always_ff @(posedge clk) begin
		case (state_q)
			cdda_pkg::ST_IDLE: begin
				if (req_fire) begin
					d_q        <= req.in_day;
					m_q        <= req.in_month;
					y_q        <= req.in_year;
					off_q      <= req.day_offset;
					valid_q    <= in_valid;
					in_range_q <= 1'b0;
					acc_q      <= '0;
					wd_q       <= cdda_pkg::EPOCH_WD;
					yi_q       <= cdda_pkg::FIRST_YEAR;
					mi_q       <= 4'd1;
				end
			end
			cdda_pkg::ST_YEAR_FWD: begin
				if (yi_q != y_q) begin
					acc_q <= alu_rsp.sum;
					wd_q  <= cdda_pkg::wd_add(wd_q, leap_i ? 3'd2 : 3'd1);
					yi_q  <= yi_q + 12'd1;
				end
			end
			cdda_pkg::ST_MONTH_FWD: begin
				if (mi_q != m_q) begin
					acc_q <= alu_rsp.sum;
					wd_q  <= cdda_pkg::wd_add(wd_q, cdda_pkg::mod7(mlen_i));
					mi_q  <= mi_q + 4'd1;
				end
			end
			cdda_pkg::ST_DAY: begin
				acc_q <= alu_rsp.sum;
				wd_q  <= cdda_pkg::wd_add(wd_q, cdda_pkg::mod7(dm1));
			end
			cdda_pkg::ST_OFFSET: begin
				days_q <= acc_q[15:0];
				acc_q  <= alu_rsp.sum;
			end
			cdda_pkg::ST_RANGE: begin
				in_range_q <= acc_in_range;
				yi_q       <= cdda_pkg::FIRST_YEAR;
				mi_q       <= 4'd1;
			end
			cdda_pkg::ST_YEAR_BACK: begin
				if (!alu_rsp.neg) begin
					acc_q <= alu_rsp.sum;
					yi_q  <= yi_q + 12'd1;
				end
			end
			cdda_pkg::ST_MONTH_BACK: begin
				if (mi_q != cdda_pkg::LAST_MONTH && !alu_rsp.neg) begin
					acc_q <= alu_rsp.sum;
					mi_q  <= mi_q + 4'd1;
				end
			end
			default: begin
			end
		endcase
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == cdda_pkg::ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == cdda_pkg::ST_DONE && out_free) begin
			o_date_valid_q <= valid_q;
			o_shift_q      <= in_range_q;
			if (!valid_q) begin
				o_days_q    <= '0;
				o_weekday_q <= '0;
				o_day_q     <= '0;
				o_month_q   <= '0;
				o_year_q    <= '0;
			end else begin
				o_days_q    <= days_q[14:0];
				o_weekday_q <= (wd_q == 3'd0) ? 3'd7 : wd_q;
				if (in_range_q) begin
					o_day_q   <= acc_q[4:0] + 5'd1;
					o_month_q <= mi_q;
					o_year_q  <= yi_q;
				end else begin
					o_day_q   <= d_q[4:0];
					o_month_q <= m_q;
					o_year_q  <= y_q;
				end
			end
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.date_valid       = o_date_valid_q;
	assign rsp.days_since_epoch = o_days_q;
	assign rsp.weekday          = o_weekday_q;
	assign rsp.shift_in_range   = o_shift_q;
	assign rsp.out_day          = o_day_q;
	assign rsp.out_month        = o_month_q;
	assign rsp.out_year         = o_year_q;

endmodule

`default_nettype wire

// ===== tb/calendar_date_day_arithmetic_tb.sv =====
// ----------------------------------------------------------------------------
// calendar_date_day_arithmetic_tb
// Self-checking bench for the date check, epoch day count, weekday and day
// shift. Dates go in over the request channel and every result transfer is
// compared field by field against a behavioral calendar predictor. A directed
// pass is followed by random dates under several idle and stall patterns.
// ----------------------------------------------------------------------------
module calendar_date_day_arithmetic_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LAST_YEAR = 2050;

	// expected contents of one result transfer
	typedef struct packed {
		logic        date_valid;
		logic [14:0] days;
		logic [2:0]  weekday;
		logic        shift_ok;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [11:0] year;
	} shifted_date_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cdda_req_if req();
	cdda_rsp_if rsp();

	calendar_date_day_arithmetic #(
		.LAST_YEAR(LAST_YEAR)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	shifted_date_t pending_dates[$];
	int unsigned   mismatch_count = 0;
	int unsigned   send_idle_pct = 0;
	int unsigned   recv_stall_pct = 0;
	int unsigned   range_days;

	always #4 clk = ~clk;

	// gregorian leap rule
	function automatic bit is_leap_year(input int unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
		case (m)
			2: begin
				return is_leap_year(y) ? 29 : 28;
			end
			4, 6, 9, 11: begin
				return 30;
			end
			default: begin
				return 31;
			end
		endcase
	endfunction

	// days from the epoch to the first of January of a year
	function automatic int unsigned days_to_year(input int unsigned y);
		int unsigned total;
		total = 0;
		for (int unsigned i = cdda_pkg::FIRST_YEAR; i < y; i++) begin
			total += is_leap_year(i) ? 366 : 365;
		end
		return total;
	endfunction

	// calendar predictor: check, count forward, shift, convert back
	function automatic shifted_date_t predict_shift(input logic [5:0] d, input logic [3:0] m,
			input logic [11:0] y, input logic signed [15:0] offset);
		shifted_date_t r;
		int unsigned   count;
		int unsigned   wd;
		int unsigned   rem;
		int unsigned   ry;
		int unsigned   rm;
		int            target;
		r = '0;
		if (y < cdda_pkg::FIRST_YEAR || y > LAST_YEAR || m < 1 || m > 12 || d < 1 ||
				d > month_length(m, y)) begin
			return r;
		end
		count = days_to_year(y);
		for (int unsigned i = 1; i < m; i++) begin
			count += month_length(i, y);
		end
		count += d - 1;
		wd = (count + 4) % 7;
		r.date_valid = 1'b1;
		r.days = count[14:0];
		r.weekday = (wd == 0) ? 3'd7 : 3'(wd);
		target = int'(count) + int'(offset);
		// shifted date outside the supported years keeps the input date
		if (target < 0 || target >= int'(days_to_year(LAST_YEAR + 1))) begin
			r.day = d[4:0];
			r.month = m;
			r.year = y;
			return r;
		end
		rem = target;
		ry = cdda_pkg::FIRST_YEAR;
		rm = 1;
		while (rem >= (is_leap_year(ry) ? 366 : 365)) begin
			rem -= is_leap_year(ry) ? 366 : 365;
			ry++;
		end
		while (rm < 12 && rem >= month_length(rm, ry)) begin
			rem -= month_length(rm, ry);
			rm++;
		end
		r.shift_ok = 1'b1;
		r.day = 5'(rem + 1);
		r.month = 4'(rm);
		r.year = 12'(ry);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("%0t ns: mismatch on %s, got %0d expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_field(input string what, input int unsigned got, input int unsigned want);
		if (got != want) begin
			report_mismatch(what, got, want);
		end
	endtask

	// one request transfer, with random idle cycles ahead of it
	task automatic send_date(input logic [5:0] d, input logic [3:0] m, input logic [11:0] y,
			input logic signed [15:0] offset);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.in_day <= d;
		req.in_month <= m;
		req.in_year <= y;
		req.day_offset <= offset;
		@(posedge clk);
		while (!req.ready) begin
			@(posedge clk);
		end
		pending_dates.push_back(predict_shift(d, m, y, offset));
		@(negedge clk);
	endtask

	// mostly well-formed dates, some near misses and raw noise
	task automatic send_random_date();
		logic [5:0]         d;
		logic [3:0]         m;
		logic [11:0]        y;
		logic signed [15:0] offset;
		int                 target;
		int unsigned        pick;
		shifted_date_t      base;
		pick = $urandom_range(99);
		if (pick < 8) begin
			send_date(6'($urandom), 4'($urandom), 12'($urandom), 16'($urandom));
		end else begin
			case ($urandom_range(9))
				0: y = cdda_pkg::FIRST_YEAR;
				1: y = 12'(LAST_YEAR);
				default: y = 12'($urandom_range(LAST_YEAR, cdda_pkg::FIRST_YEAR));
			endcase
			m = 4'($urandom_range(12, 1));
			d = 6'($urandom_range(month_length(m, y), 1));
			// near miss: one field just outside its legal range
			if (pick < 16) begin
				case ($urandom_range(5))
					0: d = 6'd0;
					1: d = 6'(month_length(m, y) + $urandom_range(3, 1));
					2: m = 4'd0;
					3: m = 4'($urandom_range(15, 13));
					4: y = 12'(cdda_pkg::FIRST_YEAR - $urandom_range(3, 1));
					default: y = 12'(LAST_YEAR + $urandom_range(3, 1));
				endcase
			end
			case ($urandom_range(9))
				0, 1, 2, 3: offset = 16'(int'($urandom_range(800)) - 400);
				4, 5, 6: offset = 16'($urandom);
				default: begin
					// aim the shift at any day of the range, edges included
					base = predict_shift(d, m, y, 16'sd0);
					target = int'($urandom_range(range_days + 60)) - 30;
					offset = 16'(target - int'(base.days));
				end
			endcase
			send_date(d, m, y, offset);
		end
	endtask

	task automatic send_random_dates(input int unsigned count);
		repeat (count) begin
			send_random_date();
		end
	endtask

	// extremes, leap rules, month lengths and range edges
	task automatic test_directed();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_date(6'd1, 4'd1, cdda_pkg::FIRST_YEAR, 16'sd0);
		send_date(6'd1, 4'd1, cdda_pkg::FIRST_YEAR, -16'sd1);
		send_date(6'd31, 4'd12, 12'(LAST_YEAR), 16'sd0);
		send_date(6'd31, 4'd12, 12'(LAST_YEAR), 16'sd1);
		send_date(6'd1, 4'd1, cdda_pkg::FIRST_YEAR, 16'(range_days - 1));
		send_date(6'd31, 4'd12, 12'(LAST_YEAR), 16'(-int'(range_days - 1)));
		send_date(6'd31, 4'd12, 12'(LAST_YEAR), 16'sh8000);
		send_date(6'd1, 4'd1, cdda_pkg::FIRST_YEAR, 16'sh7FFF);
		send_date(6'd29, 4'd2, 12'd2000, 16'sd0);
		send_date(6'd29, 4'd2, 12'd2001, 16'sd0);
		send_date(6'd30, 4'd2, 12'd2000, 16'sd0);
		send_date(6'd28, 4'd2, 12'd1972, 16'sd1);
		send_date(6'd31, 4'd12, 12'd1972, 16'sd1);
		send_date(6'd31, 4'd12, 12'd1999, 16'sd1);
		send_date(6'd1, 4'd3, 12'd2000, -16'sd1);
		send_date(6'd30, 4'd4, 12'd1970, 16'sd0);
		send_date(6'd31, 4'd4, 12'd1970, 16'sd0);
		send_date(6'd31, 4'd12, 12'(cdda_pkg::FIRST_YEAR - 1), 16'sd1);
		send_date(6'd1, 4'd1, 12'(LAST_YEAR + 1), 16'sd0);
		send_date(6'd0, 4'd0, 12'd0, 16'sd0);
		send_date(6'd63, 4'd15, 12'd4095, 16'shFFFF);
		send_date(6'd0, 4'd1, 12'd1980, 16'sd5);
		send_date(6'd32, 4'd1, 12'd1980, 16'sd5);
		send_date(6'd15, 4'd0, 12'd1980, 16'sd5);
		send_date(6'd15, 4'd13, 12'd1980, 16'sd5);
	endtask

	task automatic test_back_to_back();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_random_dates(200);
	endtask

	task automatic test_sender_idle();
		send_idle_pct = 83;
		recv_stall_pct = 0;
		send_random_dates(140);
	endtask

	task automatic test_receiver_stall();
		send_idle_pct = 0;
		recv_stall_pct = 83;
		send_random_dates(140);
	endtask

	task automatic test_mixed_idle();
		send_idle_pct = 8;
		recv_stall_pct = 8;
		send_random_dates(140);
	endtask

	// result side back-pressure
	always @(negedge clk) begin
		rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		shifted_date_t want;
		if (rsp.valid && rsp.ready) begin
			if (pending_dates.size() == 0) begin
				report_mismatch("result with no request waiting", rsp.days_since_epoch, 0);
			end else begin
				want = pending_dates.pop_front();
				check_field("date_valid", rsp.date_valid, want.date_valid);
				check_field("days_since_epoch", rsp.days_since_epoch, want.days);
				check_field("weekday", rsp.weekday, want.weekday);
				check_field("shift_in_range", rsp.shift_in_range, want.shift_ok);
				check_field("out_day", rsp.out_day, want.day);
				check_field("out_month", rsp.out_month, want.month);
				check_field("out_year", rsp.out_year, want.year);
			end
		end
	end

	initial begin
		req.valid = 1'b0;
		req.in_day = '0;
		req.in_month = '0;
		req.in_year = '0;
		req.day_offset = '0;
		rsp.ready = 1'b0;
		range_days = days_to_year(LAST_YEAR + 1);
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_back_to_back();
		test_sender_idle();
		test_receiver_stall();
		test_mixed_idle();
		req.valid <= 1'b0;
		// drain, then watch for stray results
		while (pending_dates.size() != 0) begin
			@(posedge clk);
		end
		repeat (200) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("calendar_date_day_arithmetic_tb OK");
		end else begin
			$display("calendar_date_day_arithmetic_tb NOT OK");
		end
		$finish;
	end

	// watchdog
	initial begin
		#20ms;
		$display("calendar_date_day_arithmetic_tb NOT OK");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/cdda_pkg.sv
hdl/cdda_if.sv
hdl/cdda_alu.sv
hdl/calendar_date_day_arithmetic.sv
tb/calendar_date_day_arithmetic_tb.sv
